// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked while reset is released.
`define AMCD_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Property checked on every edge, reset included.
`define AMCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/amcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package amcd_pkg;

  parameter int unsigned WINDOW_DEF  = 20;
  parameter int unsigned AXES        = 3;
  parameter int unsigned SAMPLE_W    = 16;
  parameter int unsigned SMAG_W      = SAMPLE_W + 1;
  parameter int unsigned LEVEL_W     = 8;
  parameter int unsigned LEVEL_MAX   = 200;
  parameter int unsigned PERCENT     = 100;
  parameter int unsigned PCT_W       = $clog2(PERCENT + 1);
  // 16384 counts per g
  parameter int unsigned G_SHIFT     = 14;
  // Reciprocal scale; exact for every quotient this block forms
  parameter int unsigned RECIP_SHIFT = 24;
  // Divisors are at least 3, so the reciprocal fits one bit short of the scale
  parameter int unsigned RECIP_W     = RECIP_SHIFT - 1;
  parameter int unsigned INST_RECIP  = ((1 << RECIP_SHIFT) + AXES - 1) / AXES;

  parameter logic [LEVEL_W-1:0] THRESH_RST = 8'd255;

  typedef struct packed {
    logic acc;   // beat accepted: ring read/write
    logic ld2;   // window sum update
    logic ld3;   // magnitude stage
  } lane_ctl_t;

  typedef struct packed {
    logic ld4;   // scale stage
    logic ld5;   // divide stage / output register
  } merge_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/amcd_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface amcd_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [amcd_pkg::SAMPLE_W-1:0]  accel_x;
  logic signed [amcd_pkg::SAMPLE_W-1:0]  accel_y;
  logic signed [amcd_pkg::SAMPLE_W-1:0]  accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/amcd_level_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface amcd_level_if;
  logic                           valid;
  logic                           ready;
  logic [amcd_pkg::LEVEL_W-1:0]   filtered_level;
  logic [amcd_pkg::LEVEL_W-1:0]   instant_level;
  logic                           stop_request;

  modport source (output valid, output filtered_level, output instant_level,
                  output stop_request, input ready);
  modport sink   (input valid, input filtered_level, input instant_level,
                  input stop_request, output ready);
endinterface

`default_nettype wire

// ===== rtl/amcd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module amcd_lane #(
  parameter int unsigned WINDOW = amcd_pkg::WINDOW_DEF,
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int unsigned SUM_W  = $clog2(WINDOW) + amcd_pkg::SAMPLE_W + 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  amcd_pkg::lane_ctl_t                  ctl_i,
  input  logic [SLOT_W-1:0]                    slot_i,
  input  logic signed [amcd_pkg::SAMPLE_W-1:0] sample_i,
  output logic [SUM_W-1:0]                     sum_mag_o,
  output logic [amcd_pkg::SMAG_W-1:0]          samp_mag_o
);

  logic signed [amcd_pkg::SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]                    ring_vld_q;

  logic signed [amcd_pkg::SAMPLE_W-1:0] old_q;
  logic                                 old_vld_q;
  logic signed [amcd_pkg::SAMPLE_W-1:0] new1_q;
  logic signed [amcd_pkg::SAMPLE_W-1:0] new2_q;
  logic signed [SUM_W-1:0]              sum_q;
  logic signed [SUM_W-1:0]              sum_d;
  logic signed [amcd_pkg::SAMPLE_W-1:0] old_eff;
  logic signed [amcd_pkg::SMAG_W-1:0]   new2_ext;
  logic [SUM_W-1:0]                     sum_mag_q;
  logic [amcd_pkg::SMAG_W-1:0]          samp_mag_q;

  // Read the retiring entry and overwrite it in the same beat
  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      old_q             <= ring_mem[slot_i];
      ring_mem[slot_i]  <= sample_i;
      new1_q            <= sample_i;
      old_vld_q         <= ring_vld_q[slot_i];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
    end else if (ctl_i.acc) begin
      ring_vld_q[slot_i] <= 1'b1;
    end
  end

  assign old_eff = old_vld_q ? old_q : '0;
  assign sum_d   = sum_q - SUM_W'(old_eff) + SUM_W'(new1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctl_i.ld2) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      new2_q <= new1_q;
    end
  end

  assign new2_ext = amcd_pkg::SMAG_W'(new2_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld3) begin
      sum_mag_q  <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      samp_mag_q <= new2_ext[amcd_pkg::SMAG_W-1] ? amcd_pkg::SMAG_W'(-new2_ext)
                                                 : amcd_pkg::SMAG_W'(new2_ext);
    end
  end

  assign sum_mag_o  = sum_mag_q;
  assign samp_mag_o = samp_mag_q;

endmodule

`default_nettype wire

// ===== rtl/amcd_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module amcd_merge #(
  parameter int unsigned WINDOW = amcd_pkg::WINDOW_DEF,
  localparam int unsigned SUM_W = $clog2(WINDOW) + amcd_pkg::SAMPLE_W + 1
) (
  input  logic                          clk_i,
  input  amcd_pkg::merge_ctl_t          ctl_i,
  input  logic [SUM_W-1:0]              sum_mag_i  [amcd_pkg::AXES],
  input  logic [amcd_pkg::SMAG_W-1:0]   samp_mag_i [amcd_pkg::AXES],
  input  logic [amcd_pkg::LEVEL_W-1:0]  thresh_i,
  output logic [amcd_pkg::LEVEL_W-1:0]  filtered_o,
  output logic [amcd_pkg::LEVEL_W-1:0]  instant_o,
  output logic                          stop_o
);

  localparam int unsigned AS_W       = SUM_W + 2;
  localparam int unsigned AN_W       = AS_W + amcd_pkg::PCT_W;
  localparam int unsigned T_W        = AN_W - amcd_pkg::G_SHIFT;
  localparam int unsigned FP_W       = T_W + amcd_pkg::RECIP_W;
  localparam int unsigned FILT_DIV   = amcd_pkg::AXES * WINDOW;
  localparam int unsigned FILT_RECIP = ((1 << amcd_pkg::RECIP_SHIFT) + FILT_DIV - 1) / FILT_DIV;

  localparam int unsigned BS_W = amcd_pkg::SMAG_W + 2;
  localparam int unsigned BN_W = BS_W + amcd_pkg::PCT_W;
  localparam int unsigned TI_W = BN_W - amcd_pkg::G_SHIFT;
  localparam int unsigned IP_W = TI_W + amcd_pkg::RECIP_W;

  logic [AS_W-1:0] asum;
  logic [AN_W-1:0] anum;
  logic [BS_W-1:0] bsum;
  logic [BN_W-1:0] bnum;
  logic [T_W-1:0]  tf_q;
  logic [TI_W-1:0] ti_q;
  logic [FP_W-1:0] fprod;
  logic [IP_W-1:0] iprod;
  logic [amcd_pkg::LEVEL_W-1:0] filt_q;
  logic [amcd_pkg::LEVEL_W-1:0] inst_q;

  assign asum = AS_W'(sum_mag_i[0]) + AS_W'(sum_mag_i[1]) + AS_W'(sum_mag_i[2]);
  assign anum = AN_W'(asum) * AN_W'(amcd_pkg::PERCENT);
  assign bsum = BS_W'(samp_mag_i[0]) + BS_W'(samp_mag_i[1]) + BS_W'(samp_mag_i[2]);
  assign bnum = BN_W'(bsum) * BN_W'(amcd_pkg::PERCENT);

  // Drop the counts-per-g factor first; the rest divides by a small constant
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld4) begin
      tf_q <= anum[AN_W-1:amcd_pkg::G_SHIFT];
      ti_q <= bnum[BN_W-1:amcd_pkg::G_SHIFT];
    end
  end

  // Rounded-up reciprocal: the error term stays below one quotient step
  assign fprod = FP_W'(tf_q) * FP_W'(FILT_RECIP);
  assign iprod = IP_W'(ti_q) * IP_W'(amcd_pkg::INST_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld5) begin
      filt_q <= fprod[amcd_pkg::RECIP_SHIFT +: amcd_pkg::LEVEL_W];
      inst_q <= iprod[amcd_pkg::RECIP_SHIFT +: amcd_pkg::LEVEL_W];
    end
  end

  assign filtered_o = filt_q;
  assign instant_o  = inst_q;
  assign stop_o     = (filt_q >= thresh_i);

endmodule

`default_nettype wire

// ===== rtl/accel_moving_average_crash_detect_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel      Dir  Payload                                         Beat when
// sample_i     in   accel_x, accel_y, accel_z (s16 each)            valid & ready
// level_o      out  filtered_level, instant_level (u8), stop_request valid & ready
// stop_thresh  in   stop_threshold_i (u8)                            stop_threshold_we_i
//
// One sample per cycle while the output is not stalled; each result is built in
// five stages: ring port, window sum, magnitudes, scale, reciprocal multiply.
// The ring is read and rewritten at one slot per beat, one memory port per axis.
// Reset empties the rings through per-entry valid bits; no clearing pass.
// A stalled output holds; bubbles close up stage by stage, so input stalls
// only once all five stages are full.

module accel_moving_average_crash_detect_core #(
  parameter int unsigned WINDOW = amcd_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  amcd_sample_if.sink                   sample_i,
  amcd_level_if.source                  level_o,
  input  logic                          stop_threshold_we_i,
  input  logic [amcd_pkg::LEVEL_W-1:0]  stop_threshold_i
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = $clog2(WINDOW) + amcd_pkg::SAMPLE_W + 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic [4:0] vld_q;
  logic [4:0] rdy;
  logic [4:0] ld;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] slot_d;
  logic [amcd_pkg::LEVEL_W-1:0] thr_q;

  amcd_pkg::lane_ctl_t  lane_ctl;
  amcd_pkg::merge_ctl_t merge_ctl;

  logic signed [amcd_pkg::SAMPLE_W-1:0] axis_sample [amcd_pkg::AXES];
  logic [SUM_W-1:0]                     sum_mag     [amcd_pkg::AXES];
  logic [amcd_pkg::SMAG_W-1:0]          samp_mag    [amcd_pkg::AXES];

  // A stage advances when it is empty or the next one advances
  assign rdy[4] = !vld_q[4] || level_o.ready;
  assign rdy[3] = !vld_q[3] || rdy[4];
  assign rdy[2] = !vld_q[2] || rdy[3];
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];

  assign ld[0] = sample_i.valid && rdy[0];
  assign ld[1] = vld_q[0] && rdy[1];
  assign ld[2] = vld_q[1] && rdy[2];
  assign ld[3] = vld_q[2] && rdy[3];
  assign ld[4] = vld_q[3] && rdy[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= sample_i.valid;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
      if (rdy[4]) vld_q[4] <= vld_q[3];
    end
  end

  assign slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (ld[0]) begin
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= amcd_pkg::THRESH_RST;
    end else if (stop_threshold_we_i) begin
      thr_q <= stop_threshold_i;
    end
  end

  assign lane_ctl.acc  = ld[0];
  assign lane_ctl.ld2  = ld[1];
  assign lane_ctl.ld3  = ld[2];
  assign merge_ctl.ld4 = ld[3];
  assign merge_ctl.ld5 = ld[4];

  assign axis_sample[0] = sample_i.accel_x;
  assign axis_sample[1] = sample_i.accel_y;
  assign axis_sample[2] = sample_i.accel_z;

  for (genvar g = 0; g < amcd_pkg::AXES; g++) begin : g_lane
    amcd_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl),
      .slot_i     (slot_q),
      .sample_i   (axis_sample[g]),
      .sum_mag_o  (sum_mag[g]),
      .samp_mag_o (samp_mag[g])
    );
  end

  amcd_merge #(
    .WINDOW (WINDOW)
  ) u_merge (
    .clk_i      (clk_i),
    .ctl_i      (merge_ctl),
    .sum_mag_i  (sum_mag),
    .samp_mag_i (samp_mag),
    .thresh_i   (thr_q),
    .filtered_o (level_o.filtered_level),
    .instant_o  (level_o.instant_level),
    .stop_o     (level_o.stop_request)
  );

  assign sample_i.ready = rdy[0];
  assign level_o.valid  = vld_q[4];

endmodule

`default_nettype wire

// ===== rtl/amcd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module amcd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [amcd_pkg::LEVEL_W-1:0]  filtered_i,
  input logic [amcd_pkg::LEVEL_W-1:0]  instant_i,
  input logic                          stop_i,
  input logic                          thr_we_i,
  input logic [amcd_pkg::LEVEL_W-1:0]  thr_i
);

  logic [amcd_pkg::LEVEL_W-1:0] thr_q;

  // Track the threshold as seen on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= amcd_pkg::THRESH_RST;
    end else if (thr_we_i) begin
      thr_q <= thr_i;
    end
  end

  `AMCD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(filtered_i) && $stable(instant_i), "stalled result changed")
  `AMCD_ASSERT(a_level_range, clk_i, rst_ni, out_valid_i |-> (filtered_i <= amcd_pkg::LEVEL_MAX) && (instant_i <= amcd_pkg::LEVEL_MAX), "level above full scale")
  `AMCD_ASSERT(a_stop_match, clk_i, rst_ni, out_valid_i |-> (stop_i == (filtered_i >= thr_q)), "stop flag disagrees with threshold")
  `AMCD_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_i, "result valid in reset")

endmodule

bind accel_moving_average_crash_detect_core amcd_checker u_amcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (level_o.valid),
  .out_ready_i (level_o.ready),
  .filtered_i  (level_o.filtered_level),
  .instant_i   (level_o.instant_level),
  .stop_i      (level_o.stop_request),
  .thr_we_i    (stop_threshold_we_i),
  .thr_i       (stop_threshold_i)
);

`default_nettype wire
